// ===== src/kmp_pkg.sv =====
// ----------------------------------------------------------------------------
// kmp_pkg
// shared widths, defaults and codes of the macro keypad player
// ----------------------------------------------------------------------------
package kmp_pkg;

   // default sizes of the macro store
   localparam int MACRO_LEN_DEF = 49;
   localparam int CELLS_DEF     = 9;

   // fixed field widths
   localparam int MATRIX_BITS = 9;
   localparam int TIME_W      = 32;
   localparam int CELL_W      = 4;
   localparam int SLOT_W      = 6;
   localparam int KEY_W       = 8;
   localparam int KIND_W      = 2;
   localparam int CSR_W       = 16;
   localparam int CSR_IDX_W   = 1;

   // register reset values
   localparam logic [CSR_W-1:0] INITIAL_DELAY_RST   = 16'd400;
   localparam logic [CSR_W-1:0] REPEAT_INTERVAL_RST = 16'd10;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_INITIAL_DELAY   = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_REPEAT_INTERVAL = 1'b1;

   // command codes
   localparam logic CMD_POLL  = 1'b0;
   localparam logic CMD_WRITE = 1'b1;

   // result kinds
   localparam logic [KIND_W-1:0] KIND_KEYSTROKE = 2'd0;
   localparam logic [KIND_W-1:0] KIND_RELEASE   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_WAKEUP    = 2'd2;

endpackage

// ===== src/kmp_if.sv =====
// ----------------------------------------------------------------------------
// kmp request and response channels
// valid/ready channels carrying one command word and one result word
// ----------------------------------------------------------------------------
interface kmp_req_if;
   import kmp_pkg::*;

   logic                   valid;
   logic                   ready;
   logic                   command;
   logic [MATRIX_BITS-1:0] pressed_mask;
   logic [TIME_W-1:0]      now_ms;
   logic                   hid_ready;
   logic                   bus_suspended;
   logic [CELL_W-1:0]      cell_req;
   logic [SLOT_W-1:0]      slot;
   logic [KEY_W-1:0]       key_code;
   logic [KEY_W-1:0]       key_mod;

   modport source (
      output valid, command, pressed_mask, now_ms, hid_ready, bus_suspended,
             cell_req, slot, key_code, key_mod,
      input  ready
   );

   modport sink (
      input  valid, command, pressed_mask, now_ms, hid_ready, bus_suspended,
             cell_req, slot, key_code, key_mod,
      output ready
   );
endinterface

interface kmp_rsp_if;
   import kmp_pkg::*;

   logic              valid;
   logic              ready;
   logic [KIND_W-1:0] kind;
   logic [KEY_W-1:0]  out_keycode;
   logic [KEY_W-1:0]  out_modifier;
   logic              last;

   modport source (
      output valid, kind, out_keycode, out_modifier, last,
      input  ready
   );

   modport sink (
      input  valid, kind, out_keycode, out_modifier, last,
      output ready
   );
endinterface

// ===== src/kmp_ram.sv =====
// ----------------------------------------------------------------------------
// kmp_ram
// generic simple dual port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module kmp_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 441
) (
   input  logic                                      clock,
   input  logic                                      we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                          wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                          rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== src/keypad_macro_player_with_repeat_top.sv =====
// ----------------------------------------------------------------------------
// keypad_macro_player_with_repeat_top
// 3x3 macro keypad: stores keystroke macros per cell and plays them on press
// edges, with typematic repeat, release reports and remote wakeup
// ----------------------------------------------------------------------------
// a write word or a poll without a press is handled in ST_IDLE; a release or
//   wakeup word goes through ST_FINAL into the output register once it is free
// throughput: a press plays one keystroke per cycle from the single macro ram
//   read port while the output register is free; no new word is taken meanwhile
// reset: synchronous; a clearing pass then zeroes all CELLS * MACRO_LEN slots
//   (441 by default) with req ready low; csr writes are taken meanwhile
module keypad_macro_player_with_repeat_top #(
   parameter int MACRO_LEN = kmp_pkg::MACRO_LEN_DEF,
   parameter int CELLS     = kmp_pkg::CELLS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write_en,
   input  logic [kmp_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [kmp_pkg::CSR_W-1:0]      csr_wdata,
   kmp_req_if.sink                        req_chan,
   kmp_rsp_if.source                      rsp_chan
);
   import kmp_pkg::*;

   // macro store geometry
   localparam int DEPTH = CELLS * MACRO_LEN;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int WORD_W = 2 * KEY_W;

   // sequencer states
   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_HEAD  = 3'd2;
   localparam logic [2:0] ST_NEXT  = 3'd3;
   localparam logic [2:0] ST_FINAL = 3'd4;

   // control registers
   logic [2:0]        state_ff, state_in;
   logic [AW-1:0]     addr_ff, addr_in;
   logic [AW-1:0]     end_ff, end_in;
   logic              held_ff, held_in;
   logic [TIME_W-1:0] stamp_ff, stamp_in;
   logic              rep_ff, rep_in;
   logic [CSR_W-1:0]  init_delay_ff, init_delay_in;
   logic [CSR_W-1:0]  rep_intv_ff, rep_intv_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // payload registers
   logic [KIND_W-1:0] cur_kind_ff, cur_kind_in;
   logic [KEY_W-1:0]  cur_code_ff, cur_code_in;
   logic [KEY_W-1:0]  cur_mod_ff, cur_mod_in;
   logic [KIND_W-1:0] rsp_kind_ff, rsp_kind_in;
   logic [KEY_W-1:0]  rsp_code_ff, rsp_code_in;
   logic [KEY_W-1:0]  rsp_mod_ff, rsp_mod_in;
   logic              rsp_last_ff, rsp_last_in;

   // ram port
   logic              ram_we;
   logic [AW-1:0]     ram_waddr;
   logic [WORD_W-1:0] ram_wdata;
   logic [WORD_W-1:0] ram_rdata;
   logic [KEY_W-1:0]  rd_code;
   logic [KEY_W-1:0]  rd_mod;

   // poll decode
   logic              req_fire;
   logic              out_free;
   logic              key_down;
   logic [CELL_W-1:0] cell_sel;
   logic [AW-1:0]     cell_base;
   logic              press_edge;
   logic              release_edge;
   logic [TIME_W-1:0] hold_time;
   logic [CSR_W-1:0]  interval;
   logic              wr_in_range;

   assign req_fire = req_chan.valid && req_chan.ready;
   // output register can take a word this cycle
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign rd_code  = ram_rdata[WORD_W-1:KEY_W];
   assign rd_mod   = ram_rdata[KEY_W-1:0];

   // last down cell in row-major order; mask bits past CELLS are ignored
   always_comb begin
      key_down = 1'b0;
      cell_sel = '0;
      for (int i = 0; i < MATRIX_BITS; i++) begin
         if (i < CELLS && req_chan.pressed_mask[i]) begin
            key_down = 1'b1;
            cell_sel = CELL_W'(i);
         end
      end
   end

   assign cell_base    = AW'(cell_sel * MACRO_LEN);
   assign press_edge   = key_down && !held_ff;
   assign release_edge = !key_down && held_ff;

   // stamp and repeat mode as the poll leaves them, then the timeout check
   always_comb begin
      stamp_in = stamp_ff;
      rep_in   = rep_ff;
      if (press_edge) begin
         stamp_in = req_chan.now_ms;
      end else if (release_edge) begin
         stamp_in = '0;
         rep_in   = 1'b0;
      end
      interval  = rep_in ? rep_intv_ff : init_delay_ff;
      hold_time = req_chan.now_ms - stamp_in;
      held_in   = key_down;
      if (key_down && hold_time >= {{(TIME_W - CSR_W){1'b0}}, interval}) begin
         // timeout rearms the press edge for a repeat
         held_in = 1'b0;
         rep_in  = 1'b1;
      end
   end

   assign wr_in_range = ({1'b0, req_chan.cell_req} < 5'(CELLS)) &&
                        ({2'b00, req_chan.slot} < 8'(MACRO_LEN));

   // csr writes, taken at any time
   always_comb begin
      init_delay_in = init_delay_ff;
      rep_intv_in   = rep_intv_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_INITIAL_DELAY:   init_delay_in = csr_wdata;
            CSR_REPEAT_INTERVAL: rep_intv_in   = csr_wdata;
            default: ;
         endcase
      end
   end

   // sequencer: clear pass, command decode, macro walk
   always_comb begin
      state_in     = state_ff;
      addr_in      = addr_ff;
      end_in       = end_ff;
      cur_kind_in  = cur_kind_ff;
      cur_code_in  = cur_code_ff;
      cur_mod_in   = cur_mod_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_code_in  = rsp_code_ff;
      rsp_mod_in   = rsp_mod_ff;
      rsp_last_in  = rsp_last_ff;
      ram_we       = 1'b0;
      ram_waddr    = addr_ff;
      ram_wdata    = '0;
      req_chan.ready = 1'b0;

      case (state_ff)
         ST_CLEAR: begin
            ram_we = 1'b1;
            if (addr_ff == AW'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end else begin
               addr_in = addr_ff + 1'b1;
            end
         end

         ST_IDLE: begin
            // ready is high here, so valid alone means the word is taken
            req_chan.ready = 1'b1;
            if (req_chan.valid) begin
               if (req_chan.command == CMD_WRITE) begin
                  ram_we    = wr_in_range;
                  ram_waddr = AW'(req_chan.cell_req * MACRO_LEN + req_chan.slot);
                  ram_wdata = {req_chan.key_code, req_chan.key_mod};
               end else if (req_chan.bus_suspended && key_down) begin
                  cur_kind_in = KIND_WAKEUP;
                  cur_code_in = '0;
                  cur_mod_in  = '0;
                  state_in    = ST_FINAL;
               end else if (req_chan.hid_ready) begin
                  if (press_edge) begin
                     // ram address here so the first slot reads next cycle
                     addr_in  = cell_base;
                     end_in   = AW'(cell_sel * MACRO_LEN + MACRO_LEN - 1);
                     state_in = ST_HEAD;
                  end else if (release_edge) begin
                     cur_kind_in = KIND_RELEASE;
                     cur_code_in = '0;
                     cur_mod_in  = '0;
                     state_in    = ST_FINAL;
                  end
               end
            end
         end

         ST_HEAD: begin
            // empty macro gives nothing
            if (rd_code == '0) begin
               state_in = ST_IDLE;
            end else begin
               cur_kind_in = KIND_KEYSTROKE;
               cur_code_in = rd_code;
               cur_mod_in  = rd_mod;
               if (addr_ff == end_ff) begin
                  state_in = ST_FINAL;
               end else begin
                  addr_in  = addr_ff + 1'b1;
                  state_in = ST_NEXT;
               end
            end
         end

         ST_NEXT: begin
            // the slot after the current one tells whether it is the last
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = cur_kind_ff;
               rsp_code_in  = cur_code_ff;
               rsp_mod_in   = cur_mod_ff;
               rsp_last_in  = (rd_code == '0);
               if (rd_code == '0) begin
                  state_in = ST_IDLE;
               end else begin
                  cur_code_in = rd_code;
                  cur_mod_in  = rd_mod;
                  if (addr_ff == end_ff) begin
                     state_in = ST_FINAL;
                  end else begin
                     addr_in = addr_ff + 1'b1;
                  end
               end
            end
         end

         ST_FINAL: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = cur_kind_ff;
               rsp_code_in  = cur_code_ff;
               rsp_mod_in   = cur_mod_ff;
               rsp_last_in  = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         addr_ff       <= '0;
         end_ff        <= '0;
         held_ff       <= 1'b0;
         stamp_ff      <= '0;
         rep_ff        <= 1'b0;
         init_delay_ff <= INITIAL_DELAY_RST;
         rep_intv_ff   <= REPEAT_INTERVAL_RST;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         addr_ff       <= addr_in;
         end_ff        <= end_in;
         init_delay_ff <= init_delay_in;
         rep_intv_ff   <= rep_intv_in;
         rsp_valid_ff  <= rsp_valid_in;
         // hold state moves only on a served poll
         if (req_fire && req_chan.command == CMD_POLL && req_chan.hid_ready &&
             !(req_chan.bus_suspended && key_down)) begin
            held_ff  <= held_in;
            stamp_ff <= stamp_in;
            rep_ff   <= rep_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      cur_kind_ff <= cur_kind_in;
      cur_code_ff <= cur_code_in;
      cur_mod_ff  <= cur_mod_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_code_ff <= rsp_code_in;
      rsp_mod_ff  <= rsp_mod_in;
      rsp_last_ff <= rsp_last_in;
   end

   // macro store, keycode in the upper byte; read address is the next walk
   // position so the data lines up with addr_ff
   kmp_ram #(
      .WIDTH (WORD_W),
      .DEPTH (DEPTH)
   ) u_macro_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (addr_in),
      .rdata (ram_rdata)
   );

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.kind         = rsp_kind_ff;
   assign rsp_chan.out_keycode  = rsp_code_ff;
   assign rsp_chan.out_modifier = rsp_mod_ff;
   assign rsp_chan.last         = rsp_last_ff;

`ifndef SYNTHESIS
   // every reset is followed by the clearing pass
   a_clear_after_reset: assert property (@(posedge clock)
      $past(reset) |-> state_ff == ST_CLEAR)
      else $error("clearing pass not started after reset");

   // a keystroke word never carries the end-of-macro code
   a_keystroke_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.kind == KIND_KEYSTROKE |-> rsp_chan.out_keycode != '0)
      else $error("keystroke word with zero keycode");

   // a suspended poll with a key down heads straight to the wakeup word
   a_wakeup_path: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_chan.command == CMD_POLL && req_chan.bus_suspended && key_down
      |=> state_ff == ST_FINAL && cur_kind_ff == KIND_WAKEUP)
      else $error("wakeup not scheduled");

   // the walk never runs past the end of the selected macro
   a_walk_bounded: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_NEXT |-> addr_ff <= end_ff)
      else $error("macro walk past its end");
`endif

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the 3x3 macro keypad player: loads macros, polls
// the matrix with press, hold and release sequences and checks every report
// word against a cycle-free model of the keypad kept inside the bench
// ----------------------------------------------------------------------------
module tb_top;
   import kmp_pkg::*;

   localparam int MACRO_LEN        = MACRO_LEN_DEF;
   localparam int CELLS            = CELLS_DEF;
   localparam int SLOTS_TOTAL      = MACRO_LEN * CELLS;
   // quiet time after the last report before touching registers or ending
   localparam int SETTLE_CYCLES    = 2 * (MACRO_LEN + 2);
   // receiver hold-off, long enough to back the block up into the req side
   localparam int SINK_HOLD_CYCLES = 300;
   // no handshake for this long means the block is stuck; the clearing pass
   // over all CELLS * MACRO_LEN slots after reset is the longest legal gap
   localparam int WATCHDOG_LIMIT   = 4000;
   localparam int MAX_PRINTED      = 40;

   // one command word as it goes over the req channel
   typedef struct packed {
      logic                   command;
      logic [MATRIX_BITS-1:0] pressed_mask;
      logic [TIME_W-1:0]      now_ms;
      logic                   hid_ready;
      logic                   bus_suspended;
      logic [CELL_W-1:0]      cell_req;
      logic [SLOT_W-1:0]      slot;
      logic [KEY_W-1:0]       key_code;
      logic [KEY_W-1:0]       key_mod;
   } keypad_cmd_type;

   // one report word as it comes back on the rsp channel
   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [KEY_W-1:0]  keycode;
      logic [KEY_W-1:0]  modifier;
      logic              last;
   } key_report_type;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 csr_write_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0]     csr_wdata;

   kmp_req_if req_if();
   kmp_rsp_if rsp_if();

   keypad_macro_player_with_repeat_top #(
      .MACRO_LEN (MACRO_LEN),
      .CELLS     (CELLS)
   ) i_dut (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .req_chan     (req_if),
      .rsp_chan     (rsp_if)
   );

   // model state of the keypad
   logic [KEY_W-1:0]  stored_code [SLOTS_TOTAL];
   logic [KEY_W-1:0]  stored_mod  [SLOTS_TOTAL];
   logic              key_held;
   logic [TIME_W-1:0] press_at;
   logic              in_repeat;
   logic [CSR_W-1:0]  initial_delay_cfg;
   logic [CSR_W-1:0]  repeat_interval_cfg;

   // reports still owed by the block, oldest first
   key_report_type    expected_reports [$];
   key_report_type    oldest_report;

   // millisecond time base carried across polls
   logic [TIME_W-1:0] wall_ms;
   int unsigned       mismatch_count = 0;
   int unsigned       quiet_cycles = 0;
   // no random idling on either side while set
   bit                steady_pacing = 1'b0;
   // asks the receiver process for one long hold-off
   bit                sink_stall_req = 1'b0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // model of the keypad
   // ------------------------------------------------------------------------

   function automatic void reset_keypad_model();
      for (int k = 0; k < SLOTS_TOTAL; k++) begin
         stored_code[k] = '0;
         stored_mod[k]  = '0;
      end
      key_held            = 1'b0;
      press_at            = '0;
      in_repeat           = 1'b0;
      initial_delay_cfg   = INITIAL_DELAY_RST;
      repeat_interval_cfg = REPEAT_INTERVAL_RST;
   endfunction

   // works out the reports of one accepted word and advances the model
   function automatic void predict_reports(input keypad_cmd_type w);
      int                top_cell;
      int                base;
      int                idx;
      logic              key_down;
      logic [CSR_W-1:0]  interval;
      logic [TIME_W-1:0] elapsed;
      key_report_type    r;

      if (w.command == CMD_WRITE) begin
         // out of range cell or slot: the write is dropped
         if (int'(w.cell_req) < CELLS && int'(w.slot) < MACRO_LEN) begin
            idx = int'(w.cell_req) * MACRO_LEN + int'(w.slot);
            stored_code[idx] = w.key_code;
            stored_mod[idx]  = w.key_mod;
         end
         return;
      end

      // the highest set bit in row-major order picks the macro
      top_cell = -1;
      for (int b = 0; b < CELLS && b < MATRIX_BITS; b++) begin
         if (w.pressed_mask[b]) top_cell = b;
      end
      key_down = (top_cell >= 0);

      // suspended bus with a key down only asks the host to wake up
      if (w.bus_suspended && key_down) begin
         r = '{kind: KIND_WAKEUP, keycode: '0, modifier: '0, last: 1'b1};
         expected_reports.push_back(r);
         return;
      end
      if (!w.hid_ready) return;

      // press edge: walk the macro until a zero keycode or the end
      if (key_down && !key_held) begin
         base = top_cell * MACRO_LEN;
         for (int k = 0; k < MACRO_LEN; k++) begin
            if (stored_code[base + k] == '0) break;
            r.kind     = KIND_KEYSTROKE;
            r.keycode  = stored_code[base + k];
            r.modifier = stored_mod[base + k];
            r.last     = (k == MACRO_LEN - 1) || (stored_code[base + k + 1] == '0);
            expected_reports.push_back(r);
         end
         press_at = w.now_ms;
      end
      // release edge, only while still held
      if (!key_down && key_held) begin
         r = '{kind: KIND_RELEASE, keycode: '0, modifier: '0, last: 1'b1};
         expected_reports.push_back(r);
         press_at  = '0;
         in_repeat = 1'b0;
      end

      // typematic timer: drop held so the next poll replays the macro
      key_held = key_down;
      interval = in_repeat ? repeat_interval_cfg : initial_delay_cfg;
      elapsed  = w.now_ms - press_at;
      if (key_held && elapsed >= {{(TIME_W - CSR_W){1'b0}}, interval}) begin
         key_held  = 1'b0;
         in_repeat = 1'b1;
      end
   endfunction

   // ------------------------------------------------------------------------
   // checking
   // ------------------------------------------------------------------------

   task automatic flag_mismatch(input string what);
      if (mismatch_count < MAX_PRINTED) $display("mismatch at %0t: %s", $realtime, what);
      mismatch_count++;
   endtask

   // each report word is matched against the oldest one owed
   always @(posedge clock) begin
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         if (expected_reports.size() == 0) begin
            flag_mismatch($sformatf("unexpected report kind %0d code %02h mod %02h",
                                    rsp_if.kind, rsp_if.out_keycode, rsp_if.out_modifier));
         end else begin
            oldest_report = expected_reports.pop_front();
            if (rsp_if.kind !== oldest_report.kind)
               flag_mismatch($sformatf("kind %0d, want %0d",
                                       rsp_if.kind, oldest_report.kind));
            if (rsp_if.out_keycode !== oldest_report.keycode)
               flag_mismatch($sformatf("keycode %02h, want %02h",
                                       rsp_if.out_keycode, oldest_report.keycode));
            if (rsp_if.out_modifier !== oldest_report.modifier)
               flag_mismatch($sformatf("modifier %02h, want %02h",
                                       rsp_if.out_modifier, oldest_report.modifier));
            if (rsp_if.last !== oldest_report.last)
               flag_mismatch($sformatf("last %0b, want %0b",
                                       rsp_if.last, oldest_report.last));
         end
      end
   end

   // watchdog: any handshake or register write counts as progress
   always @(posedge clock) begin
      if ((req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
          (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) || csr_write_en) begin
         quiet_cycles = 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no progress for %0d cycles", quiet_cycles);
         $display("keypad_macro_player_with_repeat_top regression: fail");
         $finish;
      end else begin
         quiet_cycles++;
      end
   end

   // receiver pacing: random idles, a steady stretch, or one long hold-off
   initial begin : sink_pacing
      int unsigned hold_left;
      hold_left = 0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (sink_stall_req) begin
            hold_left      = SINK_HOLD_CYCLES;
            sink_stall_req = 1'b0;
         end
         if (hold_left != 0) begin
            rsp_if.ready <= 1'b0;
            hold_left--;
         end else if (steady_pacing) begin
            rsp_if.ready <= 1'b1;
         end else begin
            rsp_if.ready <= ($urandom_range(0, 99) >= 31);
         end
      end
   end

   // ------------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------------

   // every field random, so unused fields of a word toggle too
   function automatic keypad_cmd_type random_word();
      keypad_cmd_type w;
      w.command       = 1'($urandom_range(0, 1));
      w.pressed_mask  = MATRIX_BITS'($urandom_range(0, (1 << MATRIX_BITS) - 1));
      w.now_ms        = $urandom();
      w.hid_ready     = 1'($urandom_range(0, 1));
      w.bus_suspended = 1'($urandom_range(0, 1));
      w.cell_req      = CELL_W'($urandom_range(0, (1 << CELL_W) - 1));
      w.slot          = SLOT_W'($urandom_range(0, (1 << SLOT_W) - 1));
      w.key_code      = KEY_W'($urandom_range(0, 255));
      w.key_mod       = KEY_W'($urandom_range(0, 255));
      return w;
   endfunction

   // offers one word and returns at the edge that takes it; valid is left
   // high so a following word goes out back to back
   task automatic send_word(input keypad_cmd_type w);
      int unsigned gap;
      gap = 0;
      if (!steady_pacing) begin
         while (gap < 8 && $urandom_range(0, 99) < 31) gap++;
      end
      if (gap != 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid         <= 1'b1;
      req_if.command       <= w.command;
      req_if.pressed_mask  <= w.pressed_mask;
      req_if.now_ms        <= w.now_ms;
      req_if.hid_ready     <= w.hid_ready;
      req_if.bus_suspended <= w.bus_suspended;
      req_if.cell_req      <= w.cell_req;
      req_if.slot          <= w.slot;
      req_if.key_code      <= w.key_code;
      req_if.key_mod       <= w.key_mod;
      @(posedge clock);
      while (req_if.ready !== 1'b1) @(posedge clock);
      predict_reports(w);
   endtask

   task automatic send_write(input int cell_idx, input int slot_pos,
                             input int code, input int modifier);
      keypad_cmd_type w;
      w              = random_word();
      w.command      = CMD_WRITE;
      w.cell_req     = cell_idx[CELL_W-1:0];
      w.slot         = slot_pos[SLOT_W-1:0];
      w.key_code     = code[KEY_W-1:0];
      w.key_mod      = modifier[KEY_W-1:0];
      send_word(w);
   endtask

   task automatic send_poll(input logic [MATRIX_BITS-1:0] mask,
                            input logic [TIME_W-1:0] stamp,
                            input logic host_ready, input logic suspended);
      keypad_cmd_type w;
      w               = random_word();
      w.command       = CMD_POLL;
      w.pressed_mask  = mask;
      w.now_ms        = stamp;
      w.hid_ready     = host_ready;
      w.bus_suspended = suspended;
      send_word(w);
   endtask

   // sender stops and waits out every owed report plus the block's tail
   task automatic settle_block();
      req_if.valid <= 1'b0;
      while (expected_reports.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // only called with the block settled
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_W-1:0] value);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= value;
      @(posedge clock);
      if (idx == CSR_INITIAL_DELAY) initial_delay_cfg = value;
      else repeat_interval_cfg = value;
      csr_write_en <= 1'b0;
      @(posedge clock);
   endtask

   // nonzero keycodes, then a terminator unless the macro is full
   task automatic load_macro(input int cell_idx, input int len);
      for (int s = 0; s < len; s++) begin
         send_write(cell_idx, s, $urandom_range(1, 255), $urandom_range(0, 255));
      end
      if (len < MACRO_LEN) send_write(cell_idx, len, 0, $urandom_range(0, 255));
   endtask

   // mostly short macros, now and then a full one
   function automatic int pick_macro_len();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 70) return $urandom_range(0, 4);
      if (roll < 95) return $urandom_range(5, 12);
      return MACRO_LEN;
   endfunction

   // time between polls, scaled to the current delays so repeats do fire
   function automatic logic [TIME_W-1:0] hold_step();
      case ($urandom_range(0, 7))
         0, 1, 2: return $urandom_range(0, 3);
         3:       return $urandom_range(0, 2 * int'(repeat_interval_cfg) + 2);
         4:       return $urandom_range(0, 2 * int'(initial_delay_cfg) + 2);
         5, 6:    return TIME_W'(in_repeat ? repeat_interval_cfg : initial_delay_cfg);
         default: return $urandom();
      endcase
   endfunction

   // press one key (maybe with lower keys), hold a few polls, let go
   task automatic hold_session();
      int unsigned            cell_idx;
      logic [MATRIX_BITS-1:0] mask;
      cell_idx = $urandom_range(0, CELLS - 1);
      mask     = '0;
      mask[cell_idx] = 1'b1;
      for (int b = 0; b < cell_idx; b++) mask[b] = 1'($urandom_range(0, 1));
      repeat ($urandom_range(1, 6)) begin
         wall_ms += hold_step();
         send_poll(mask, wall_ms, $urandom_range(0, 9) != 0, $urandom_range(0, 19) == 0);
      end
      repeat ($urandom_range(1, 2)) begin
         wall_ms += hold_step();
         send_poll('0, wall_ms, $urandom_range(0, 9) != 0, $urandom_range(0, 9) == 0);
      end
   endtask

   // mostly well-formed sessions, some macro edits and raw noise
   task automatic random_mix(input int rounds);
      repeat (rounds) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: hold_session();
            5:             load_macro($urandom_range(0, CELLS - 1), pick_macro_len());
            6, 7:          send_word(random_word());
            default: begin
               wall_ms += hold_step();
               send_poll(MATRIX_BITS'($urandom_range(0, (1 << MATRIX_BITS) - 1)), wall_ms,
                         $urandom_range(0, 3) != 0, $urandom_range(0, 4) == 0);
            end
         endcase
      end
   endtask

   task automatic apply_delays(input logic [CSR_W-1:0] delay, input logic [CSR_W-1:0] interval);
      settle_block();
      write_csr(CSR_INITIAL_DELAY, delay);
      write_csr(CSR_REPEAT_INTERVAL, interval);
      repeat (2) hold_session();
   endtask

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------

   // hand-picked words: field extremes, every kind, the corner cases
   task automatic test_directed_cases();
      send_write(0, 0, 8'hFF, 8'h00);
      send_write(0, 1, 8'h01, 8'hFF);
      send_write(0, 2, 8'h00, 8'h5A);
      send_write(1, 0, 8'h80, 8'h81);
      send_write(1, 1, 8'h00, 8'h00);
      // writes outside the store are dropped
      send_write(CELLS, 0, 8'h05, 8'h05);
      send_write((1 << CELL_W) - 1, (1 << SLOT_W) - 1, 8'h06, 8'h06);
      send_write(CELLS - 1, MACRO_LEN, 8'h07, 8'h07);
      send_poll(9'h000, 32'd0, 1'b1, 1'b0);     // nothing down
      send_poll(9'h001, 32'd100, 1'b1, 1'b0);   // press plays cell 0
      send_poll(9'h001, 32'd101, 1'b1, 1'b0);   // still held, too early to repeat
      send_poll(9'h000, 32'd102, 1'b1, 1'b0);   // release report
      send_poll(9'h1FF, 32'd103, 1'b1, 1'b1);   // suspended with keys down: wakeup
      send_poll(9'h100, 32'd104, 1'b0, 1'b0);   // host not ready
      send_poll(9'h100, 32'd105, 1'b1, 1'b0);   // empty macro plays nothing
      send_poll(9'h000, 32'd106, 1'b1, 1'b0);   // but the release still reports
      send_poll(9'h003, 32'd107, 1'b1, 1'b0);   // two keys: the later cell wins
      send_poll(9'h000, 32'd108, 1'b0, 1'b1);   // suspended with nothing down
      send_poll(9'h000, 32'd109, 1'b1, 1'b0);
      // typematic across the 32-bit time wrap, then a release after timeout
      wall_ms = 32'hFFFF_FF00;
      send_poll(9'h001, wall_ms, 1'b1, 1'b0);
      wall_ms += TIME_W'(initial_delay_cfg);
      send_poll(9'h001, wall_ms, 1'b1, 1'b0);   // initial delay runs out
      wall_ms += 1;
      send_poll(9'h001, wall_ms, 1'b1, 1'b0);   // replay
      wall_ms += TIME_W'(repeat_interval_cfg);
      send_poll(9'h001, wall_ms, 1'b1, 1'b0);   // repeat interval runs out
      wall_ms += 1;
      send_poll(9'h000, wall_ms, 1'b1, 1'b0);   // no release report after timeout
   endtask

   // a macro with every slot used plays all of them, also on repeat
   task automatic test_full_macro();
      load_macro(4, MACRO_LEN);
      wall_ms += 5;
      send_poll(9'h010, wall_ms, 1'b1, 1'b0);
      wall_ms += TIME_W'(initial_delay_cfg);
      send_poll(9'h010, wall_ms, 1'b1, 1'b0);
      wall_ms += 1;
      send_poll(9'h010, wall_ms, 1'b1, 1'b0);
      wall_ms += 1;
      send_poll(9'h000, wall_ms, 1'b1, 1'b0);
   endtask

   task automatic test_random_traffic();
      for (int c = 0; c < CELLS; c++) load_macro(c, pick_macro_len());
      random_mix(4);
   endtask

   // both delays at zero, one and full scale, mixed, random, then defaults
   task automatic test_register_extremes();
      apply_delays(16'd0, 16'd0);
      apply_delays(16'd1, 16'd1);
      apply_delays(16'hFFFF, 16'hFFFF);
      apply_delays(16'hFFFF, 16'd0);
      apply_delays(CSR_W'($urandom_range(1, 65535)), CSR_W'($urandom_range(1, 65535)));
      apply_delays(INITIAL_DELAY_RST, REPEAT_INTERVAL_RST);
   endtask

   // receiver holds off while presses keep coming, so the block backs up
   task automatic test_receiver_stall();
      load_macro(2, 20);
      sink_stall_req = 1'b1;
      repeat (6) begin
         wall_ms += 1;
         send_poll(9'h004, wall_ms, 1'b1, 1'b0);
         wall_ms += 1;
         send_poll(9'h000, wall_ms, 1'b1, 1'b0);
      end
      settle_block();
   endtask

   // both sides at full rate
   task automatic test_steady_stream();
      steady_pacing = 1'b1;
      random_mix(6);
      steady_pacing = 1'b0;
   endtask

   // ------------------------------------------------------------------------
   // run
   // ------------------------------------------------------------------------

   initial begin
      reset_keypad_model();
      wall_ms = '0;
      // every input known from time zero
      reset                <= 1'b1;
      csr_write_en         <= 1'b0;
      csr_index            <= CSR_INITIAL_DELAY;
      csr_wdata            <= '0;
      req_if.valid         <= 1'b0;
      req_if.command       <= CMD_POLL;
      req_if.pressed_mask  <= '0;
      req_if.now_ms        <= '0;
      req_if.hid_ready     <= 1'b0;
      req_if.bus_suspended <= 1'b0;
      req_if.cell_req      <= '0;
      req_if.slot          <= '0;
      req_if.key_code      <= '0;
      req_if.key_mod       <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // req side stays blocked through the clearing pass; send_word waits
      test_directed_cases();
      test_full_macro();
      test_random_traffic();
      test_register_extremes();
      test_receiver_stall();
      test_steady_stream();
      settle_block();

      if (mismatch_count == 0) begin
         $display("keypad_macro_player_with_repeat_top regression: pass");
      end else begin
         $display("keypad_macro_player_with_repeat_top regression: fail");
      end
      $finish;
   end

endmodule
